@@ hw/rtl/fcbf_pkg.sv @@
// Shared types and constants for the fire cooling blur filter.
`default_nettype none
package fcbf_pkg;

  typedef logic [7:0] pix_t;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_COOLING = 2'd2;

  localparam int CFG_AW    = 4;
  localparam int CFG_DIM_W = 10;

  localparam int MIN_WIDTH  = 5;
  localparam int MIN_HEIGHT = 4;
  localparam int AVG_SHIFT  = 3;

  localparam logic [CFG_DIM_W-1:0] RST_WIDTH  = 10'd480;
  localparam logic [CFG_DIM_W-1:0] RST_HEIGHT = 10'd360;
  localparam pix_t                 RST_COOL   = 8'd4;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // 3x3 neighborhood of the pixel being finished.
  typedef struct packed {
    pix_t nw;
    pix_t n;
    pix_t ne;
    pix_t w;
    pix_t e;
    pix_t sw;
    pix_t s;
    pix_t se;
    pix_t center;
    logic interior;
  } window_t;

  typedef struct packed {
    pix_t value;
    logic frame_end;
  } out_beat_t;

endpackage
`default_nettype wire

@@ hw/rtl/fcbf_delay_ring.sv @@
// Circular delay line in a synchronous single-port memory with registered read.
`default_nettype none
module fcbf_delay_ring #(
  parameter int DEPTH = 509
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       clr,
  input  wire logic                       adv,
  input  wire logic [$clog2(DEPTH)-1:0]   last,
  input  wire fcbf_pkg::pix_t             wdata,
  output fcbf_pkg::pix_t                  rdata_r
);
  import fcbf_pkg::*;

  localparam int AW = $clog2(DEPTH);

  pix_t          mem [DEPTH];
  logic [AW-1:0] ptr_r;
  logic [AW-1:0] ptr_nxt;

  // The entry under the pointer is the oldest one: read it out and replace it.
  always_ff @(posedge clk) begin
    if (adv) begin
      rdata_r    <= mem[ptr_r];
      mem[ptr_r] <= wdata;
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (clr) begin
      ptr_nxt = '0;
    end else if (adv) begin
      ptr_nxt = (ptr_r == last) ? '0 : ptr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/fcbf_kernel.sv @@
// Neighbor average minus cooling, floored at zero; border pixels pass through.
`default_nettype none
module fcbf_kernel (
  input  wire fcbf_pkg::window_t win,
  input  wire fcbf_pkg::pix_t    cooling,
  output fcbf_pkg::pix_t         result
);
  import fcbf_pkg::*;

  logic [10:0] sum;
  pix_t        avg;

  always_comb begin
    sum = ((11'(win.nw) + 11'(win.n)) + (11'(win.ne) + 11'(win.e)))
        + ((11'(win.sw) + 11'(win.s)) + (11'(win.se) + 11'(win.w)));
    avg = pix_t'(sum >> AVG_SHIFT);
    if (!win.interior) begin
      result = win.center;
    end else if (avg > cooling) begin
      result = avg - cooling;
    end else begin
      result = '0;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/fcbf_out_skid.sv @@
// Two-entry output stage: a main register and a skid register.
`default_nettype none
module fcbf_out_skid (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire fcbf_pkg::out_beat_t push_beat,
  output logic                     space,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output fcbf_pkg::out_beat_t      out_beat
);
  import fcbf_pkg::*;

  logic      main_vld_r;
  logic      skid_vld_r;
  out_beat_t main_r;
  out_beat_t skid_r;
  logic      pop;

  assign pop        = main_vld_r && out_tready;
  assign space      = !skid_vld_r;
  assign out_tvalid = main_vld_r;
  assign out_beat   = main_r;

  // The producer is held off while the skid entry is full, so push and a
  // full skid entry never meet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (main_vld_r && !pop) begin
        skid_vld_r <= 1'b1;
      end else begin
        main_vld_r <= 1'b1;
      end
    end else if (pop) begin
      main_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (main_vld_r && !pop) begin
        skid_r <= push_beat;
      end else begin
        main_r <= push_beat;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/fire_cooling_blur_filter.sv @@
// Top level of the streaming fire cooling blur filter.
//
// Pixels of an 8-bit frame enter in raster order on the in_ channel, one beat
// per pixel (in_tuser = 0). Each interior pixel leaves as the average of its
// eight neighbors minus the cooling register, floored at zero; neighbors above
// and to the left count with their filtered values. Border pixels pass through.
// Results leave on the out_ channel in raster order, width+1 pixel beats behind
// the input; after the last pixel, width+1 flush beats (in_tuser = 1) drain the
// rest, and the result of the final pixel carries out_tlast. Beats that fall
// outside this pattern are taken and dropped.
// Throughput is one beat per cycle: the row history lives in two circular
// memories (originals and finished values), each read and written once per
// beat, and the kernel finishes one pixel per cycle. Each result is
// registered into the output stage as its beat is accepted. A two-entry output
// stage keeps in_tready high while one result waits on a stalled receiver;
// in_tready falls only when both entries are full. A synchronous reset empties
// the output stage, restarts the frame and loads 480x360 with cooling 4.
// Writing frame_width or frame_height restarts the frame.
`default_nettype none
module fire_cooling_blur_filter #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // in_tdata: [7:0] pixel_value
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,
  // in_tuser: [0] opcode
  input  wire logic                          in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // out_tdata: [7:0] out_value
  output logic [7:0]                         out_tdata,
  output logic                               out_tlast,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [fcbf_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import fcbf_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int OD  = MAX_WIDTH - 3;
  localparam int FD  = MAX_WIDTH - 2;
  localparam int OAW = $clog2(OD);
  localparam int FAW = $clog2(FD);

  // Configuration registers, raw for readback, clamped for use.
  logic [CFG_DIM_W-1:0] width_raw_r;
  logic [CFG_DIM_W-1:0] height_raw_r;
  pix_t                 cooling_r;
  logic [WW-1:0]        eff_w_r;
  logic [HW-1:0]        eff_h_r;
  logic [WW-1:0]        eff_w_nxt;
  logic [HW-1:0]        eff_h_nxt;
  logic [31:0]          dim_raw;
  logic                 cfg_wr;
  logic                 geom_wr;

  // Frame position tracking.
  logic [CW-1:0] in_col_r;
  logic [RW-1:0] in_row_r;
  logic          in_full_r;
  logic          started_r;
  logic [CW-1:0] out_col_r;
  logic [RW-1:0] out_row_r;

  logic [CW-1:0] w_last;
  logic [CW-1:0] w_m3;
  logic [RW-1:0] h_last;
  logic [RW-1:0] h_m3;

  logic in_acc;
  logic pix_ok;
  logic flush_ok;
  logic emit;
  logic in_last_pix;
  logic out_last;
  logic frame_done;
  logic orig_adv;

  // Original-pixel taps and finished-pixel taps around the pixel in flight.
  pix_t orig_px;
  pix_t a1_r;
  pix_t a2_r;
  pix_t ctr_r;
  pix_t orig_rd;
  pix_t f1_r;
  pix_t fb_r;
  pix_t fc_r;
  pix_t fin_rd;

  window_t   win;
  pix_t      result;
  out_beat_t push_beat;
  out_beat_t out_beat;
  logic      space;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign geom_wr    = cfg_wr && (cfg_paddr[3:2] == REG_WIDTH || cfg_paddr[3:2] == REG_HEIGHT);
  assign dim_raw    = {{(32 - CFG_DIM_W){1'b0}}, cfg_pwdata[CFG_DIM_W-1:0]};

  always_comb begin
    if (dim_raw < 32'(MIN_WIDTH)) begin
      eff_w_nxt = WW'(MIN_WIDTH);
    end else if (dim_raw > 32'(MAX_WIDTH)) begin
      eff_w_nxt = WW'(MAX_WIDTH);
    end else begin
      eff_w_nxt = WW'(dim_raw);
    end
    if (dim_raw < 32'(MIN_HEIGHT)) begin
      eff_h_nxt = HW'(MIN_HEIGHT);
    end else if (dim_raw > 32'(MAX_HEIGHT)) begin
      eff_h_nxt = HW'(MAX_HEIGHT);
    end else begin
      eff_h_nxt = HW'(dim_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_raw_r  <= RST_WIDTH;
      height_raw_r <= RST_HEIGHT;
      cooling_r    <= RST_COOL;
      eff_w_r      <= WW'(RST_WIDTH);
      eff_h_r      <= HW'(RST_HEIGHT);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_WIDTH: begin
          width_raw_r <= cfg_pwdata[CFG_DIM_W-1:0];
          eff_w_r     <= eff_w_nxt;
        end
        REG_HEIGHT: begin
          height_raw_r <= cfg_pwdata[CFG_DIM_W-1:0];
          eff_h_r      <= eff_h_nxt;
        end
        REG_COOLING: begin
          cooling_r <= cfg_pwdata[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_WIDTH:   cfg_prdata = {{(32 - CFG_DIM_W){1'b0}}, width_raw_r};
      REG_HEIGHT:  cfg_prdata = {{(32 - CFG_DIM_W){1'b0}}, height_raw_r};
      REG_COOLING: cfg_prdata = {24'd0, cooling_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // Geometry-derived limits; the clamped sizes always fit these widths.
  assign w_last = CW'(eff_w_r - WW'(1));
  assign w_m3   = CW'(eff_w_r - WW'(3));
  assign h_last = RW'(eff_h_r - HW'(1));
  assign h_m3   = RW'(eff_h_r - HW'(3));

  assign in_tready = space;
  assign in_acc    = in_tvalid && in_tready;

  // A pixel beat counts until the frame is full; a flush beat counts only
  // once it is full. Output starts after width+1 pixels are in.
  assign pix_ok      = in_acc && (in_tuser == OP_PIXEL) && !in_full_r;
  assign flush_ok    = in_acc && (in_tuser == OP_FLUSH) && in_full_r;
  assign emit        = (pix_ok && started_r) || flush_ok;
  assign orig_adv    = pix_ok || flush_ok;
  assign in_last_pix = (in_row_r == h_last) && (in_col_r == w_last);
  assign out_last    = (out_row_r == h_last) && (out_col_r == w_last);
  assign frame_done  = flush_ok && out_last;

  always_ff @(posedge clk) begin
    if (!rst_n || geom_wr || frame_done) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      in_full_r <= 1'b0;
      started_r <= 1'b0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      if (pix_ok) begin
        if (in_row_r == RW'(1) && in_col_r == '0) begin
          started_r <= 1'b1;
        end
        if (in_last_pix) begin
          in_full_r <= 1'b1;
        end
        if (in_col_r == w_last) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + RW'(1);
        end else begin
          in_col_r <= in_col_r + CW'(1);
        end
      end
      if (emit) begin
        if (out_col_r == w_last) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + RW'(1);
        end else begin
          out_col_r <= out_col_r + CW'(1);
        end
      end
    end
  end

  // Original stream: in_tdata, then two registers, then the ring, then the
  // center register. Flush beats push zeros that no interior pixel reads.
  assign orig_px = (in_tuser == OP_FLUSH) ? '0 : in_tdata;

  always_ff @(posedge clk) begin
    if (orig_adv) begin
      a1_r  <= orig_px;
      a2_r  <= a1_r;
      ctr_r <= orig_rd;
    end
  end

  fcbf_delay_ring #(
    .DEPTH (OD)
  ) u_orig_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (geom_wr),
    .adv     (orig_adv),
    .last    (OAW'(eff_w_r - WW'(4))),
    .wdata   (a2_r),
    .rdata_r (orig_rd)
  );

  // Finished stream: each result feeds back as the left neighbor and, one
  // row later, as the three upper neighbors.
  always_ff @(posedge clk) begin
    if (emit) begin
      f1_r <= result;
      fb_r <= fin_rd;
      fc_r <= fb_r;
    end
  end

  fcbf_delay_ring #(
    .DEPTH (FD)
  ) u_fin_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (geom_wr),
    .adv     (emit),
    .last    (FAW'(eff_w_r - WW'(3))),
    .wdata   (result),
    .rdata_r (fin_rd)
  );

  always_comb begin
    win.nw       = fc_r;
    win.n        = fb_r;
    win.ne       = fin_rd;
    win.w        = f1_r;
    win.e        = orig_rd;
    win.sw       = a2_r;
    win.s        = a1_r;
    win.se       = orig_px;
    win.center   = ctr_r;
    win.interior = (out_row_r != '0) && (out_row_r <= h_m3)
                && (out_col_r != '0) && (out_col_r <= w_m3);
  end

  fcbf_kernel u_kernel (
    .win     (win),
    .cooling (cooling_r),
    .result  (result)
  );

  assign push_beat.value     = result;
  assign push_beat.frame_end = frame_done;

  fcbf_out_skid u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (emit),
    .push_beat  (push_beat),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_beat   (out_beat)
  );

  assign out_tdata = out_beat.value;
  assign out_tlast = out_beat.frame_end;

endmodule
`default_nettype wire

@@ hw/rtl/fcbf_checker.sv @@
// Port-level checks for the fire cooling blur filter and their bind.
`default_nettype none
module fcbf_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tready,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [7:0]                  out_tdata,
  input wire logic                        out_tlast,
  input wire logic                        cfg_psel,
  input wire logic                        cfg_penable,
  input wire logic                        cfg_pwrite,
  input wire logic [fcbf_pkg::CFG_AW-1:0] cfg_paddr,
  input wire logic [31:0]                 cfg_pwdata,
  input wire logic [31:0]                 cfg_prdata,
  input wire logic                        cfg_pready
);
  import fcbf_pkg::*;

  logic cool_wr;
  assign cool_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                && (cfg_paddr[3:2] == REG_COOLING);

  // A held result keeps its beat until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // Reset empties the output stage.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // Input is never held off while the output stage is empty; in the design it
  // is held off only once a second result waits on a stalled receiver.
  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input held off with the output stage empty");

  // A cooling write reads back on the next cycle at the same address.
  a_cool_rb: assert property (@(posedge clk) disable iff (!rst_n)
    cool_wr |=> (cfg_paddr[3:2] != REG_COOLING)
             || (cfg_prdata[7:0] == $past(cfg_pwdata[7:0])))
    else $error("cooling register readback mismatch");

endmodule

bind fire_cooling_blur_filter fcbf_checker u_fcbf_checker (.*);
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking stream testbench for the fire cooling blur filter.
`timescale 1ns / 1ps

module testbench;
  import fcbf_pkg::*;

  localparam int FRAME_MAX_W   = 512;
  localparam int FRAME_MAX_H   = 512;
  localparam int RING_DEPTH    = 2 * FRAME_MAX_W + 2;
  // The result is registered into the output stage as its beat is taken, and
  // the stage holds two entries; this many quiet cycles covers all of that.
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BEATS  = 360;
  localparam int PRINT_LIMIT   = 100;

  // One input beat: opcode travels on tuser, the pixel on tdata.
  typedef struct packed {
    logic op;
    pix_t px;
  } raster_beat_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;
  logic        in_tuser    = OP_PIXEL;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  fire_cooling_blur_filter #(
    .MAX_WIDTH (FRAME_MAX_W),
    .MAX_HEIGHT(FRAME_MAX_H)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Beats waiting to be sent, and filtered pixels waiting to come out.
  raster_beat_t raster_q[$];
  out_beat_t    filtered_q[$];

  int unsigned mismatch_count    = 0;
  int unsigned sender_idle_pct   = 15;
  int unsigned receiver_idle_pct = 88;
  int unsigned random_beats      = 0;
  bit          geometry_dirty    = 1'b0;

  // Predictor state: the registers as written, the row history ring and the
  // two raster positions. The ring is 2W+2 entries deep for the current width.
  logic [CFG_DIM_W-1:0] width_reg   = RST_WIDTH;
  logic [CFG_DIM_W-1:0] height_reg  = RST_HEIGHT;
  pix_t                 cooling_reg = RST_COOL;
  pix_t                 history [RING_DEPTH];
  int unsigned          in_pos  = 0;
  int unsigned          out_pos = 0;

  function automatic int unsigned clamp_dim(int unsigned raw, int unsigned lo,
                                            int unsigned hi);
    if (raw < lo) return lo;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // Finish raster position o. The newest neighbor (below right) is passed in
  // because it may not be in the ring yet. Interior pixels are written back
  // so that later neighbors above and to the left see the filtered value.
  function automatic pix_t cool_pixel(int unsigned o, pix_t newest, int unsigned w,
                                      int unsigned h);
    int unsigned ring, r, c, sum, avg;
    pix_t v;
    ring = 2 * w + 2;
    r = o / w;
    c = o % w;
    if (r >= 1 && r + 3 <= h && c >= 1 && c + 3 <= w) begin
      sum = 0;
      sum += history[(o - w - 1) % ring];
      sum += history[(o - w) % ring];
      sum += history[(o - w + 1) % ring];
      sum += history[(o - 1) % ring];
      sum += history[(o + 1) % ring];
      sum += history[(o + w - 1) % ring];
      sum += history[(o + w) % ring];
      sum += newest;
      avg = sum >> AVG_SHIFT;
      v = (avg > cooling_reg) ? pix_t'(avg - cooling_reg) : '0;
      history[o % ring] = v;
      return v;
    end
    return history[o % ring];
  endfunction

  // Advance the predictor by one accepted beat and queue any result it causes.
  function automatic void absorb_beat(logic op, pix_t px);
    int unsigned w, h, total, ring;
    out_beat_t res;
    w = clamp_dim(width_reg, MIN_WIDTH, FRAME_MAX_W);
    h = clamp_dim(height_reg, MIN_HEIGHT, FRAME_MAX_H);
    total = w * h;
    ring = 2 * w + 2;
    if (op == OP_PIXEL) begin
      // Pixels beyond a full frame are dropped until the drain finishes.
      if (in_pos < total) begin
        if (in_pos >= w + 1) begin
          res.value = cool_pixel(out_pos, px, w, h);
          res.frame_end = (out_pos + 1 == total);
          filtered_q.push_back(res);
          out_pos++;
        end
        history[in_pos % ring] = px;
        in_pos++;
      end
    end else if (in_pos >= total && out_pos < total) begin
      // A flush only counts once the whole frame is in and results remain.
      res.value = cool_pixel(out_pos, history[(out_pos + w + 1) % ring], w, h);
      out_pos++;
      res.frame_end = (out_pos == total);
      if (res.frame_end) begin
        in_pos = 0;
        out_pos = 0;
      end
      filtered_q.push_back(res);
    end
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("[%0t] check failed: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Sender: a beat stays on the bus until taken, then the next one from the
  // queue goes out unless this cycle is chosen as a gap.
  always @(posedge clk) begin : drive_in
    raster_beat_t beat;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (raster_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        beat = raster_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= beat.op;
        in_tdata <= beat.px;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: predicts from every input beat taken at this edge, then checks
  // any result beat taken at the same edge, and draws the receiver's stalls.
  // Doing both in one block fixes the order of push and pop.
  always @(posedge clk) begin : watch_out
    out_beat_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_beat(in_tuser, in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (filtered_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat, value %0d last %0b",
                                    out_tdata, out_tlast));
        end else begin
          want = filtered_q.pop_front();
          if (out_tdata !== want.value) begin
            report_mismatch($sformatf("pixel value %0d, expected %0d",
                                      out_tdata, want.value));
          end
          if (out_tlast !== want.frame_end) begin
            report_mismatch($sformatf("frame end flag %0b, expected %0b",
                                      out_tlast, want.frame_end));
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // Register write: setup cycle, then access until pready. The predictor
  // takes the new value at the write edge; the block is idle by then.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_WIDTH: begin
        width_reg = value[CFG_DIM_W-1:0];
        in_pos = 0;
        out_pos = 0;
      end
      REG_HEIGHT: begin
        height_reg = value[CFG_DIM_W-1:0];
        in_pos = 0;
        out_pos = 0;
      end
      REG_COOLING: cooling_reg = value[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Everything sent and every expected result received, plus the quiet
  // cycles for beats that produce nothing.
  task automatic wait_idle();
    while (raster_q.size() != 0 || in_tvalid || filtered_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic pix_t random_pixel();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_beat(logic op, pix_t px);
    raster_q.push_back('{op: op, px: px});
  endfunction

  // Pixels of a frame; with noise, stray flushes land mid-frame and must be
  // dropped since the frame is not complete.
  function automatic void push_pixels(int unsigned count, bit noisy);
    for (int unsigned i = 0; i < count; i++) begin
      if (noisy && $urandom_range(0, 24) == 0) push_beat(OP_FLUSH, random_pixel());
      push_beat(OP_PIXEL, random_pixel());
    end
  endfunction

  // The W+1 flushes that drain a frame. With noise, stray pixels arrive after
  // the full frame, and a flush may follow when nothing is left to drain.
  function automatic void push_drain(int unsigned w, bit noisy);
    if (noisy && $urandom_range(0, 2) == 0) push_beat(OP_PIXEL, random_pixel());
    for (int unsigned i = 0; i <= w; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) push_beat(OP_PIXEL, random_pixel());
      push_beat(OP_FLUSH, pix_t'($urandom_range(0, 255)));
    end
    if (noisy && $urandom_range(0, 5) == 0) push_beat(OP_FLUSH, random_pixel());
  endfunction

  // One random frame on a small geometry. Sizes below the minimum are
  // written on purpose so that the clamp is exercised. Now and then the frame
  // is cut short, and the next geometry write must throw it away.
  task automatic random_frame();
    int unsigned w, h, total, len;
    if (geometry_dirty || $urandom_range(0, 2) == 0) begin
      wait_idle();
      write_reg(REG_WIDTH, $urandom_range(2, 10));
      write_reg(REG_HEIGHT, $urandom_range(1, 7));
    end
    if ($urandom_range(0, 3) == 0) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0: write_reg(REG_COOLING, 32'd0);
        1: write_reg(REG_COOLING, 32'd255);
        default: write_reg(REG_COOLING, $urandom_range(0, 24));
      endcase
    end
    w = clamp_dim(width_reg, MIN_WIDTH, FRAME_MAX_W);
    h = clamp_dim(height_reg, MIN_HEIGHT, FRAME_MAX_H);
    total = w * h;
    geometry_dirty = ($urandom_range(0, 7) == 0);
    len = geometry_dirty ? $urandom_range(1, total - 1) : total;
    push_pixels(len, 1'b1);
    random_beats += len;
    if (!geometry_dirty) begin
      push_drain(w, 1'b1);
      random_beats += w + 1;
    end
  endtask

  initial begin : stimulus
    for (int i = 0; i < RING_DEPTH; i++) history[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // At the reset geometry a flush is early and dropped; two pixels start a
    // frame that the geometry write below must discard.
    push_beat(OP_FLUSH, 8'hA5);
    push_beat(OP_PIXEL, 8'hFF);
    push_beat(OP_PIXEL, 8'h5A);
    wait_idle();

    // Smallest frame, 5x4: its two interior pixels are finished with the
    // cooling at its extremes. With all-255 neighbors the sum is at its top
    // and cooling 0 keeps 255; cooling 255 then floors the next one at zero.
    write_reg(REG_WIDTH, 32'd5);
    write_reg(REG_HEIGHT, 32'd4);
    write_reg(REG_COOLING, 32'd0);
    for (int i = 0; i < 13; i++) push_beat(OP_PIXEL, 8'hFF);
    wait_idle();
    write_reg(REG_COOLING, 32'd255);
    push_beat(OP_PIXEL, 8'h00);
    for (int i = 0; i < 6; i++) push_beat(OP_PIXEL, random_pixel());
    push_beat(OP_PIXEL, 8'h3C);
    push_drain(5, 1'b0);
    push_beat(OP_FLUSH, 8'h00);
    wait_idle();

    // Saturated geometries: width 0 runs as 5 and height 1023 as 512, then
    // width 1023 runs as 512. Each short run starts a frame that the next
    // geometry write throws away.
    write_reg(REG_COOLING, 32'd3);
    write_reg(REG_WIDTH, 32'd0);
    write_reg(REG_HEIGHT, 32'd1023);
    push_pixels(8 * MIN_WIDTH, 1'b0);
    wait_idle();
    write_reg(REG_WIDTH, 32'd1023);
    write_reg(REG_HEIGHT, 32'd512);
    push_pixels(2 * MIN_WIDTH, 1'b0);
    wait_idle();

    // Random frames: the receiver stalls first, then the sender gaps more,
    // and finally both run flat out.
    geometry_dirty = 1'b1;
    while (random_beats < RANDOM_BEATS) begin
      if (random_beats < RANDOM_BEATS / 3) begin
        sender_idle_pct = 15;
        receiver_idle_pct = 88;
      end else if (random_beats < 2 * RANDOM_BEATS / 3) begin
        sender_idle_pct = 88;
        receiver_idle_pct = 15;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      random_frame();
    end
    wait_idle();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake; a correct run needs far less than this.
  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
